[rtl/cia_pkg.sv]
// Package for the checked integer ALU: opcodes, status codes, sequencer states
// and the control structs passed between the sequencer and the shared unit.
// No dependencies.
package cia_pkg;

   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_MOD  = 3'd4,
      CMD_POW  = 3'd5,
      CMD_FACT = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_OVF    = 2'd1,
      ST_DIV0   = 2'd2,
      ST_NEGFAC = 2'd3
   } status_type;

   typedef enum logic {
      UOP_MUL = 1'b0,
      UOP_DIV = 1'b1
   } unit_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_GO,
      S_MUL_WAIT,
      S_DIV_GO,
      S_DIV_WAIT,
      S_POW_TEST,
      S_POW_MUL_GO,
      S_POW_MUL_WAIT,
      S_POW_SQR_GO,
      S_POW_SQR_WAIT,
      S_FACT_TEST,
      S_FACT_GO,
      S_FACT_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic done;
      logic hi_nz;
   } unit_sts_type;

   typedef struct packed {
      logic start;
      logic ack;
   } ctrl_cmd_type;

   typedef struct packed {
      logic busy;
      logic res_valid;
   } ctrl_sts_type;

endpackage

[rtl/cia_unit.sv]
// Shared multi-cycle arithmetic unit: shift-add multiplier and restoring divider
// on unsigned magnitudes, both built round one double-width adder.
// Depends on cia_pkg.
module cia_unit import cia_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  unit_ctl_type          ctl,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output unit_sts_type          sts,
   output logic [DATA_WIDTH-1:0] res_lo,
   output logic [DATA_WIDTH-1:0] res_hi
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   unit_op_type           op_ff, op_in;
   logic [PW-1:0]         acc_ff, acc_in;
   logic [PW-1:0]         mcand_ff, mcand_in;
   logic [DATA_WIDTH-1:0] mplier_ff, mplier_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   logic [PW-1:0] shl_acc;
   logic [PW-1:0] add_x;
   logic [PW-1:0] add_y;
   logic          cin;
   logic [PW:0]   sum;

   // multiply: acc + multiplicand; divide: shifted remainder minus divisor
   always_comb begin
      shl_acc = {acc_ff[PW-2:0], 1'b0};
      if (op_ff == UOP_MUL) begin
         add_x = acc_ff;
         add_y = mcand_ff;
         cin   = 1'b0;
      end else begin
         add_x = {{DATA_WIDTH{1'b0}}, shl_acc[PW-1:DATA_WIDTH]};
         add_y = {{DATA_WIDTH{1'b1}}, ~mcand_ff[DATA_WIDTH-1:0]};
         cin   = 1'b1;
      end
      sum = {1'b0, add_x} + {1'b0, add_y} + {{PW{1'b0}}, cin};
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         op_in     = ctl.op;
         cnt_in    = '0;
         mplier_in = opb;
         if (ctl.op == UOP_MUL) begin
            acc_in   = '0;
            mcand_in = {{DATA_WIDTH{1'b0}}, opa};
         end else begin
            acc_in   = {{DATA_WIDTH{1'b0}}, opa};
            mcand_in = {{DATA_WIDTH{1'b0}}, opb};
         end
      end else if (busy_ff) begin
         case (op_ff)
            UOP_MUL: begin
               // stops as soon as no multiplier bits are left
               if (mplier_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (mplier_ff[0]) begin
                     acc_in = sum[PW-1:0];
                  end
                  mcand_in  = {mcand_ff[PW-2:0], 1'b0};
                  mplier_in = mplier_ff >> 1;
               end
            end
            UOP_DIV: begin
               if (sum[PW]) begin
                  acc_in = {sum[DATA_WIDTH-1:0], shl_acc[DATA_WIDTH-1:1], 1'b1};
               end else begin
                  acc_in = shl_acc;
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CW'(DATA_WIDTH - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign sts.done  = done_ff;
   assign sts.hi_nz = |acc_ff[PW-1:DATA_WIDTH];
   assign res_lo    = acc_ff[DATA_WIDTH-1:0];
   assign res_hi    = acc_ff[PW-1:DATA_WIDTH];

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("unit started while busy");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("unit done held for more than one cycle");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (done_ff && op_ff == UOP_DIV) |->
         (acc_ff[PW-1:DATA_WIDTH] < mcand_ff[DATA_WIDTH-1:0]))
      else $error("remainder not below divisor");

endmodule

[rtl/cia_ctrl.sv]
// Sequencer of the checked integer ALU: decodes the opcode, runs the multiply,
// divide, power and factorial loops on the shared unit and forms result and status.
// Depends on cia_pkg; drives cia_unit.
module cia_ctrl import cia_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          ccmd,
   input  cmd_type               op_cmd,
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   output ctrl_sts_type          csts,
   output logic [DATA_WIDTH-1:0] result,
   output status_type            status,
   output unit_ctl_type          uctl,
   output logic [DATA_WIDTH-1:0] uopa,
   output logic [DATA_WIDTH-1:0] uopb,
   input  unit_sts_type          usts,
   input  logic [DATA_WIDTH-1:0] ulo,
   input  logic [DATA_WIDTH-1:0] uhi
);

   localparam logic [DATA_WIDTH-1:0] ONE  = DATA_WIDTH'(1);
   localparam logic [DATA_WIDTH-1:0] TWO  = DATA_WIDTH'(2);
   localparam logic [DATA_WIDTH-1:0] ONES = {DATA_WIDTH{1'b1}};
   localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] base_ff, base_in;
   logic [DATA_WIDTH-1:0] expo_ff, expo_in;
   logic [DATA_WIDTH-1:0] idx_ff, idx_in;
   logic                  big_ff, big_in;
   logic                  base_big_ff, base_big_in;
   logic                  neg_ff, neg_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   status_type            status_ff, status_in;

   logic                  a_neg, b_neg, sgn_diff;
   logic [DATA_WIDTH-1:0] ma, mb, op_ma;
   logic [DATA_WIDTH-1:0] add_r, sub_r;
   logic [DATA_WIDTH-1:0] mul_lim, pow_lim, rem_s;
   logic [DATA_WIDTH-1:0] imm_res;
   status_type            imm_status;

   always_comb begin
      a_neg    = a_ff[DATA_WIDTH-1];
      b_neg    = b_ff[DATA_WIDTH-1];
      sgn_diff = a_neg ^ b_neg;
      ma       = a_neg ? (~a_ff + ONE) : a_ff;
      mb       = b_neg ? (~b_ff + ONE) : b_ff;
      op_ma    = op_a[DATA_WIDTH-1] ? (~op_a + ONE) : op_a;
      mul_lim  = sgn_diff ? SMIN : SMAX;
      pow_lim  = neg_ff ? SMIN : SMAX;
      rem_s    = a_neg ? (~uhi + ONE) : uhi;
      add_r    = op_a + op_b;
      sub_r    = op_a - op_b;
   end

   // results settled in the beat cycle: add, sub, negative-exponent pow, errors
   always_comb begin
      imm_res    = '0;
      imm_status = ST_OK;
      case (op_cmd)
         CMD_ADD: begin
            imm_res = add_r;
            if (op_a[DATA_WIDTH-1] == op_b[DATA_WIDTH-1] &&
                add_r[DATA_WIDTH-1] != op_a[DATA_WIDTH-1]) begin
               imm_status = ST_OVF;
            end
         end
         CMD_SUB: begin
            imm_res = sub_r;
            if (op_a[DATA_WIDTH-1] != op_b[DATA_WIDTH-1] &&
                sub_r[DATA_WIDTH-1] != op_a[DATA_WIDTH-1]) begin
               imm_status = ST_OVF;
            end
         end
         CMD_DIV, CMD_MOD: begin
            if (op_b == '0) begin
               imm_status = ST_DIV0;
            end
         end
         CMD_POW: begin
            // only used for a negative exponent
            if (op_a == ONE) begin
               imm_res = ONE;
            end else if (op_a == ONES) begin
               imm_res = op_b[0] ? ONES : ONE;
            end else begin
               imm_status = ST_OVF;
            end
         end
         CMD_FACT: begin
            imm_status = ST_NEGFAC;
         end
         default: ;
      endcase
   end

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ccmd.start) begin
               case (op_cmd)
                  CMD_MUL:          state_in = S_MUL_GO;
                  CMD_DIV, CMD_MOD: state_in = (op_b == '0) ? S_DONE : S_DIV_GO;
                  CMD_POW:  state_in = op_b[DATA_WIDTH-1] ? S_DONE : S_POW_TEST;
                  CMD_FACT: state_in = op_a[DATA_WIDTH-1] ? S_DONE : S_FACT_TEST;
                  default:          state_in = S_DONE;
               endcase
            end
         end
         S_MUL_GO:   state_in = S_MUL_WAIT;
         S_MUL_WAIT: if (usts.done) state_in = S_DONE;
         S_DIV_GO:   state_in = S_DIV_WAIT;
         S_DIV_WAIT: if (usts.done) state_in = S_DONE;
         S_POW_TEST: begin
            if (expo_ff == '0) begin
               state_in = S_DONE;
            end else if (expo_ff[0]) begin
               state_in = S_POW_MUL_GO;
            end else begin
               state_in = S_POW_SQR_GO;
            end
         end
         S_POW_MUL_GO: state_in = S_POW_MUL_WAIT;
         S_POW_MUL_WAIT: begin
            if (usts.done) begin
               state_in = (expo_ff[DATA_WIDTH-1:1] == '0) ? S_POW_TEST : S_POW_SQR_GO;
            end
         end
         S_POW_SQR_GO:   state_in = S_POW_SQR_WAIT;
         S_POW_SQR_WAIT: if (usts.done) state_in = S_POW_TEST;
         S_FACT_TEST: begin
            if (idx_ff > a_ff || acc_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FACT_GO;
            end
         end
         S_FACT_GO:   state_in = S_FACT_WAIT;
         S_FACT_WAIT: if (usts.done) state_in = S_FACT_TEST;
         S_DONE:      if (ccmd.ack) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin : outputs
      uctl.start = 1'b0;
      uctl.op    = UOP_MUL;
      uopa       = ma;
      uopb       = mb;
      case (state_ff)
         S_MUL_GO: begin
            uctl.start = 1'b1;
         end
         S_DIV_GO: begin
            uctl.start = 1'b1;
            uctl.op    = UOP_DIV;
         end
         S_POW_MUL_GO: begin
            uctl.start = 1'b1;
            uopa       = base_ff;
            uopb       = acc_ff;
         end
         S_POW_SQR_GO: begin
            uctl.start = 1'b1;
            uopa       = base_ff;
            uopb       = base_ff;
         end
         S_FACT_GO: begin
            // small factor as multiplier keeps the step short
            uctl.start = 1'b1;
            uopa       = acc_ff;
            uopb       = idx_ff;
         end
         default: ;
      endcase
      csts.busy      = (state_ff != S_IDLE);
      csts.res_valid = (state_ff == S_DONE);
      result         = res_ff;
      status         = status_ff;
   end

   always_comb begin : data_next
      cmd_in      = cmd_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      acc_in      = acc_ff;
      base_in     = base_ff;
      expo_in     = expo_ff;
      idx_in      = idx_ff;
      big_in      = big_ff;
      base_big_in = base_big_ff;
      neg_in      = neg_ff;
      res_in      = res_ff;
      status_in   = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (ccmd.start) begin
               cmd_in      = op_cmd;
               a_in        = op_a;
               b_in        = op_b;
               acc_in      = ONE;
               base_in     = op_ma;
               expo_in     = op_b;
               idx_in      = TWO;
               big_in      = 1'b0;
               base_big_in = 1'b0;
               neg_in      = op_a[DATA_WIDTH-1] & op_b[0];
               res_in      = imm_res;
               status_in   = imm_status;
            end
         end
         S_MUL_WAIT: begin
            if (usts.done) begin
               res_in    = sgn_diff ? (~ulo + ONE) : ulo;
               status_in = (usts.hi_nz || ulo > mul_lim) ? ST_OVF : ST_OK;
            end
         end
         S_DIV_WAIT: begin
            if (usts.done) begin
               status_in = ST_OK;
               if (cmd_ff == CMD_DIV) begin
                  res_in = sgn_diff ? (~ulo + ONE) : ulo;
                  // most negative by minus one wraps
                  if (a_ff == SMIN && b_ff == ONES) begin
                     status_in = ST_OVF;
                  end
               end else begin
                  // floored: a non-zero remainder takes the divisor's sign
                  res_in = (uhi != '0 && sgn_diff) ? (rem_s + b_ff) : rem_s;
               end
            end
         end
         S_POW_TEST: begin
            if (expo_ff == '0) begin
               res_in    = neg_ff ? (~acc_ff + ONE) : acc_ff;
               status_in = (big_ff || acc_ff > pow_lim) ? ST_OVF : ST_OK;
            end
         end
         S_POW_MUL_WAIT: begin
            if (usts.done) begin
               acc_in = ulo;
               big_in = big_ff | base_big_ff | usts.hi_nz;
               if (expo_ff[DATA_WIDTH-1:1] == '0) begin
                  expo_in = '0;
               end
            end
         end
         S_POW_SQR_WAIT: begin
            if (usts.done) begin
               base_in     = ulo;
               base_big_in = base_big_ff | usts.hi_nz;
               expo_in     = expo_ff >> 1;
            end
         end
         S_FACT_TEST: begin
            if (idx_ff > a_ff || acc_ff == '0) begin
               res_in    = acc_ff;
               status_in = (big_ff || acc_ff > SMAX) ? ST_OVF : ST_OK;
            end
         end
         S_FACT_WAIT: begin
            if (usts.done) begin
               acc_in = ulo;
               big_in = big_ff | usts.hi_nz;
               idx_in = idx_ff + ONE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      expo_ff     <= expo_in;
      idx_ff      <= idx_in;
      big_ff      <= big_in;
      base_big_ff <= base_big_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
   end

   a_beat_when_idle: assert property (@(posedge clock) disable iff (reset)
      ccmd.start |-> state_ff == S_IDLE)
      else $error("beat taken while sequencer busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      usts.done |-> (state_ff == S_MUL_WAIT || state_ff == S_DIV_WAIT ||
                     state_ff == S_POW_MUL_WAIT || state_ff == S_POW_SQR_WAIT ||
                     state_ff == S_FACT_WAIT))
      else $error("unit finished outside a wait state");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !ccmd.ack) |=>
         (state_ff == S_DONE && $stable(res_ff) && $stable(status_ff)))
      else $error("finished result changed before hand-off");

endmodule

[rtl/checked_integer_alu_top.sv]
// Top level of the checked integer ALU: request and response handshakes, operand
// sizing and the response register.
// Depends on cia_pkg, cia_unit and cia_ctrl.

// Checked integer ALU. One request beat carries an opcode (add, sub, mul,
// truncating div, floored mod, power, factorial) and two signed 32-bit
// operands; one response beat returns the DATA_WIDTH-bit result, sign-extended
// or truncated to 32 bits, and a status (ok, overflow, divide by zero,
// negative factorial operand). Overflow returns the wrapped low bits. One item
// is in work at a time and req_stall is high until its result has moved into
// the response register, which then holds it while the next request is taken.
// Work per opcode, with W = DATA_WIDTH: add, sub, unused opcode and error cases
// need no unit work; mul stops once the bits of |operand_b| are used up; div
// and mod take all W quotient bits; power runs one test per exponent bit, one
// squaring per exponent bit below the top one and one multiply per set bit;
// factorial runs one multiply per factor i, stopping once i passes operand_a
// or the low W bits reach zero (at most about W factors). All of this is set
// by the shared shift-add / restoring-divide unit, which retires one bit per
// cycle.
module checked_integer_alu_top import cia_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result,
   output logic [1:0]         rsp_status
);

   ctrl_cmd_type          ccmd;
   ctrl_sts_type          csts;
   unit_ctl_type          uctl;
   unit_sts_type          usts;
   logic [DATA_WIDTH-1:0] op_a, op_b;
   logic [DATA_WIDTH-1:0] res, uopa, uopb, ulo, uhi;
   status_type            status;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_result_ff, rsp_result_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               load;

   // sign-extend or wrap to the working width
   assign op_a = DATA_WIDTH'(req_operand_a);
   assign op_b = DATA_WIDTH'(req_operand_b);

   assign req_stall  = csts.busy;
   assign ccmd.start = req_valid & ~csts.busy;
   assign load       = csts.res_valid & (~rsp_valid_ff | ~rsp_stall);
   assign ccmd.ack   = load;

   cia_ctrl #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .ccmd   (ccmd),
      .op_cmd (cmd_type'(req_cmd)),
      .op_a   (op_a),
      .op_b   (op_b),
      .csts   (csts),
      .result (res),
      .status (status),
      .uctl   (uctl),
      .uopa   (uopa),
      .uopb   (uopb),
      .usts   (usts),
      .ulo    (ulo),
      .uhi    (uhi)
   );

   cia_unit #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (uctl),
      .opa    (uopa),
      .opb    (uopb),
      .sts    (usts),
      .res_lo (ulo),
      .res_hi (uhi)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = 32'(signed'(res));
         rsp_status_in = status;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

endmodule
